// ----- rtl/http_request_line_parser_core_defines.svh -----
// ----------------------------------------------------------------------------
// HTTP request line parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH
`define HTTP_REQUEST_LINE_PARSER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define HRLP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define HRLP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/hrlp_pkg.sv -----
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Payload types, parser state and result codes, character constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrlp_pkg;

   localparam int OFFSET_WIDTH  = 12;
   localparam int VERSION_WIDTH = 10;

   localparam logic [VERSION_WIDTH-1:0] VER_MAX = 10'd999;

   // Characters recognized by the parser
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_SPACE      = 8'h20;
   localparam logic [7:0] CH_DOT        = 8'h2E;
   localparam logic [7:0] CH_SLASH      = 8'h2F;
   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_ONE        = 8'h31;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UPPER_A    = 8'h41;
   localparam logic [7:0] CH_UPPER_H    = 8'h48;
   localparam logic [7:0] CH_UPPER_P    = 8'h50;
   localparam logic [7:0] CH_UPPER_T    = 8'h54;
   localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

   // Method names packed one byte per character, first byte highest
   localparam logic [31:0] WORD_GET  = 32'h0047_4554;
   localparam logic [31:0] WORD_POST = 32'h504F_5354;
   localparam logic [31:0] WORD_HEAD = 32'h4845_4144;

   typedef enum logic [3:0] {
      PS_START,
      PS_METHOD,
      PS_SP_URI,
      PS_URI,
      PS_HTTP,
      PS_H,
      PS_HT,
      PS_HTT,
      PS_HTTP_SL,
      PS_MAJ_FIRST,
      PS_MAJ,
      PS_MIN_FIRST,
      PS_MIN,
      PS_SP_AFTER,
      PS_ALMOST
   } parse_state_type;

   typedef enum logic [1:0] {
      STAT_MORE,
      STAT_DONE,
      STAT_BAD_METHOD,
      STAT_BAD_REQUEST
   } status_type;

   typedef enum logic [1:0] {
      METH_UNKNOWN,
      METH_GET,
      METH_POST,
      METH_HEAD
   } method_type;

   typedef struct packed {
      logic [7:0] byte_in;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]               status;
      logic [1:0]               method_code;
      logic [VERSION_WIDTH-1:0] version_major;
      logic [VERSION_WIDTH-1:0] version_minor;
      logic [OFFSET_WIDTH-1:0]  method_end_offset;
      logic [OFFSET_WIDTH-1:0]  uri_start_offset;
      logic [OFFSET_WIDTH-1:0]  uri_end_offset;
      logic [OFFSET_WIDTH-1:0]  request_end_offset;
   } rsp_payload_type;

endpackage

// ----- rtl/hrlp_stream_if.sv -----
// ----------------------------------------------------------------------------
// HTTP request line parser stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hrlp_stream_if #(
   parameter type payload_type = logic
);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (
      output valid,
      output payload,
      input  ready
   );

   modport sink (
      input  valid,
      input  payload,
      output ready
   );

endinterface

// ----- rtl/hrlp_parser.sv -----
// ----------------------------------------------------------------------------
// HTTP request line parser state machine
// Holds the parse state and captured fields, forms the result of each byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_line_parser_core_defines.svh"

module hrlp_parser import hrlp_pkg::*; #(
   parameter int OFFSET_LIMIT = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_en,
   input  logic [7:0]      byte_in,
   output rsp_payload_type result
);

   localparam int OFF_CAP_INT = ((OFFSET_LIMIT - 1) < 4095) ? (OFFSET_LIMIT - 1) : 4095;
   localparam logic [OFFSET_WIDTH-1:0] OFF_CAP = OFFSET_WIDTH'(OFF_CAP_INT);

   function automatic logic is_method_char(input logic [7:0] c);
      return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // v * 10 + digit, saturating at the version limit
   function automatic logic [VERSION_WIDTH-1:0] next_version(
      input logic [VERSION_WIDTH-1:0] v,
      input logic [7:0]               c
   );
      logic [13:0] n;
      n = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {10'b0, c[3:0]};
      return (n > {4'b0000, VER_MAX}) ? VER_MAX : n[VERSION_WIDTH-1:0];
   endfunction

   function automatic method_type classify(
      input logic [31:0] word,
      input logic [2:0]  len
   );
      if ((len == 3'd3) && (word == WORD_GET))  return METH_GET;
      if ((len == 3'd4) && (word == WORD_POST)) return METH_POST;
      if ((len == 3'd4) && (word == WORD_HEAD)) return METH_HEAD;
      return METH_UNKNOWN;
   endfunction

   parse_state_type          state_ff,       state_in,       state_upd;
   logic [OFFSET_WIDTH-1:0]  byte_offset_ff, byte_offset_in;
   logic [31:0]              method_bytes_ff, method_bytes_in, method_bytes_upd;
   logic [2:0]               method_len_ff,  method_len_in,  method_len_upd;
   method_type               method_ff,      method_in,      method_upd;
   logic [VERSION_WIDTH-1:0] major_ff,       major_in,       major_upd;
   logic [VERSION_WIDTH-1:0] minor_ff,       minor_in,       minor_upd;
   logic [OFFSET_WIDTH-1:0]  method_end_ff,  method_end_in,  method_end_upd;
   logic [OFFSET_WIDTH-1:0]  uri_begin_ff,   uri_begin_in,   uri_begin_upd;
   logic [OFFSET_WIDTH-1:0]  uri_end_ff,     uri_end_in,     uri_end_upd;
   logic [OFFSET_WIDTH-1:0]  req_end_ff,     req_end_in,     req_end_upd;
   logic                     req_end_vld_ff, req_end_vld_in, req_end_vld_upd;
   status_type               status;

   // Register the parse state and captured fields, advance on each byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= PS_START;
         byte_offset_ff  <= '0;
         method_bytes_ff <= '0;
         method_len_ff   <= '0;
         method_ff       <= METH_UNKNOWN;
         major_ff        <= '0;
         minor_ff        <= '0;
         method_end_ff   <= '0;
         uri_begin_ff    <= '0;
         uri_end_ff      <= '0;
         req_end_ff      <= '0;
         req_end_vld_ff  <= 1'b0;
      end else if (step_en) begin
         state_ff        <= state_in;
         byte_offset_ff  <= byte_offset_in;
         method_bytes_ff <= method_bytes_in;
         method_len_ff   <= method_len_in;
         method_ff       <= method_in;
         major_ff        <= major_in;
         minor_ff        <= minor_in;
         method_end_ff   <= method_end_in;
         uri_begin_ff    <= uri_begin_in;
         uri_end_ff      <= uri_end_in;
         req_end_ff      <= req_end_in;
         req_end_vld_ff  <= req_end_vld_in;
      end
   end

   // Next state, captured fields and result for the current byte
   always_comb begin
      state_upd        = state_ff;
      method_bytes_upd = method_bytes_ff;
      method_len_upd   = method_len_ff;
      method_upd       = method_ff;
      major_upd        = major_ff;
      minor_upd        = minor_ff;
      method_end_upd   = method_end_ff;
      uri_begin_upd    = uri_begin_ff;
      uri_end_upd      = uri_end_ff;
      req_end_upd      = req_end_ff;
      req_end_vld_upd  = req_end_vld_ff;
      status           = STAT_MORE;

      unique case (state_ff)
         PS_METHOD: begin
            if (byte_in == CH_SPACE) begin
               method_end_upd = byte_offset_ff;
               method_upd     = classify(method_bytes_ff, method_len_ff);
               state_upd      = PS_SP_URI;
            end else if (is_method_char(byte_in)) begin
               // keep the first four bytes, count up to seven
               if (method_len_ff < 3'd4) begin
                  method_bytes_upd = {method_bytes_ff[23:0], byte_in};
               end
               if (method_len_ff < 3'd7) begin
                  method_len_upd = method_len_ff + 3'd1;
               end
            end else begin
               status = STAT_BAD_METHOD;
            end
         end
         PS_SP_URI: begin
            if (byte_in == CH_SLASH) begin
               uri_begin_upd = byte_offset_ff;
               state_upd     = PS_URI;
            end else if (byte_in != CH_SPACE) begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_URI: begin
            // everything but a space belongs to the URI
            if (byte_in == CH_SPACE) begin
               uri_end_upd = byte_offset_ff;
               state_upd   = PS_HTTP;
            end
         end
         PS_HTTP: begin
            if (byte_in == CH_UPPER_H) begin
               state_upd = PS_H;
            end else if (byte_in != CH_SPACE) begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_H: begin
            if (byte_in == CH_UPPER_T) state_upd = PS_HT;
            else status = STAT_BAD_REQUEST;
         end
         PS_HT: begin
            if (byte_in == CH_UPPER_T) state_upd = PS_HTT;
            else status = STAT_BAD_REQUEST;
         end
         PS_HTT: begin
            if (byte_in == CH_UPPER_P) state_upd = PS_HTTP_SL;
            else status = STAT_BAD_REQUEST;
         end
         PS_HTTP_SL: begin
            if (byte_in == CH_SLASH) state_upd = PS_MAJ_FIRST;
            else status = STAT_BAD_REQUEST;
         end
         PS_MAJ_FIRST: begin
            // a leading zero in the major version is rejected
            if ((byte_in >= CH_ONE) && (byte_in <= CH_NINE)) begin
               major_upd = {6'b0, byte_in[3:0]};
               state_upd = PS_MAJ;
            end else begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_MAJ: begin
            if (byte_in == CH_DOT) begin
               state_upd = PS_MIN_FIRST;
            end else if (is_digit(byte_in)) begin
               major_upd = next_version(major_ff, byte_in);
            end else begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_MIN_FIRST: begin
            if (is_digit(byte_in)) begin
               minor_upd = {6'b0, byte_in[3:0]};
               state_upd = PS_MIN;
            end else begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_MIN, PS_SP_AFTER: begin
            if (byte_in == CH_CR) begin
               req_end_upd     = byte_offset_ff;
               req_end_vld_upd = 1'b1;
               state_upd       = PS_ALMOST;
            end else if (byte_in == CH_LF) begin
               status = STAT_DONE;
            end else if (byte_in == CH_SPACE) begin
               state_upd = PS_SP_AFTER;
            end else if ((state_ff == PS_MIN) && is_digit(byte_in)) begin
               minor_upd = next_version(minor_ff, byte_in);
            end else begin
               status = STAT_BAD_REQUEST;
            end
         end
         PS_ALMOST: begin
            status = (byte_in == CH_LF) ? STAT_DONE : STAT_BAD_REQUEST;
         end
         default: begin
            // start: skip line breaks, open a method on a method character
            if ((byte_in == CH_CR) || (byte_in == CH_LF)) begin
               state_upd = PS_START;
            end else if (is_method_char(byte_in)) begin
               method_bytes_upd = {24'b0, byte_in};
               method_len_upd   = 3'd1;
               state_upd        = PS_METHOD;
            end else begin
               status = STAT_BAD_METHOD;
            end
         end
      endcase

      // bare LF ends the line at its own offset
      if ((status == STAT_DONE) && !req_end_vld_ff) begin
         req_end_upd     = byte_offset_ff;
         req_end_vld_upd = 1'b1;
      end

      result.status             = status;
      result.method_code        = method_upd;
      result.version_major      = major_upd;
      result.version_minor      = minor_upd;
      result.method_end_offset  = method_end_upd;
      result.uri_start_offset   = uri_begin_upd;
      result.uri_end_offset     = uri_end_upd;
      result.request_end_offset = (status == STAT_DONE) ? req_end_upd : '0;

      // drop everything after a finished or failed line
      if (status != STAT_MORE) begin
         state_in        = PS_START;
         byte_offset_in  = '0;
         method_bytes_in = '0;
         method_len_in   = '0;
         method_in       = METH_UNKNOWN;
         major_in        = '0;
         minor_in        = '0;
         method_end_in   = '0;
         uri_begin_in    = '0;
         uri_end_in      = '0;
         req_end_in      = '0;
         req_end_vld_in  = 1'b0;
      end else begin
         state_in        = state_upd;
         byte_offset_in  = (byte_offset_ff < OFF_CAP) ? byte_offset_ff + OFFSET_WIDTH'(1)
                                                      : byte_offset_ff;
         method_bytes_in = method_bytes_upd;
         method_len_in   = method_len_upd;
         method_in       = method_upd;
         major_in        = major_upd;
         minor_in        = minor_upd;
         method_end_in   = method_end_upd;
         uri_begin_in    = uri_begin_upd;
         uri_end_in      = uri_end_upd;
         req_end_in      = req_end_upd;
         req_end_vld_in  = req_end_vld_upd;
      end
   end

   `HRLP_ASSERT_NEXT(a_result_restarts, clock, reset, step_en && (status != STAT_MORE),
      (state_ff == PS_START) && (byte_offset_ff == '0),
      "line end or error did not restart the parser")
   `HRLP_ASSERT_SAME(a_offset_capped, clock, reset, 1'b1, byte_offset_ff <= OFF_CAP,
      "byte offset passed its saturation value")
   `HRLP_ASSERT_SAME(a_method_after_space, clock, reset, method_ff != METH_UNKNOWN,
      (state_ff != PS_START) && (state_ff != PS_METHOD),
      "method classified before the method ended")

endmodule

// ----- rtl/http_request_line_parser_core.sv -----
// ----------------------------------------------------------------------------
// HTTP request line parser core
// A result is registered and shown in the cycle after its byte transaction.
// Throughput: one byte per cycle while the sink takes each result; the result register frees as it is taken.
// Every byte yields exactly one result transaction.
// Reset: synchronous; parser returns to start with all offsets and versions 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_request_line_parser_core_defines.svh"

module http_request_line_parser_core import hrlp_pkg::*; #(
   parameter int OFFSET_LIMIT = 4096
) (
   input logic           clock,
   input logic           reset,
   hrlp_stream_if.sink   req_stream,
   hrlp_stream_if.source rsp_stream
);

   logic            req_ready;
   logic            step_en;
   rsp_payload_type step_result;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   // Take a byte whenever the result register is empty or being drained
   assign req_ready = !rsp_valid_ff || rsp_stream.ready;
   assign step_en   = req_stream.valid && req_ready;

   hrlp_parser #(
      .OFFSET_LIMIT (OFFSET_LIMIT)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .byte_in (req_stream.payload.byte_in),
      .result  (step_result)
   );

   // Hold the result until the sink takes the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_payload_ff <= step_result;
      end
   end

   assign req_stream.ready   = req_ready;
   assign rsp_stream.valid   = rsp_valid_ff;
   assign rsp_stream.payload = rsp_payload_ff;

   `HRLP_ASSERT_NEXT(a_accept_fills, clock, reset, step_en, rsp_valid_ff, "accepted byte produced no result")
   `HRLP_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_stream.ready, !step_en, "pending result overwritten")
   `HRLP_ASSERT_SAME(a_end_only_done, clock, reset, rsp_valid_ff && (rsp_payload_ff.status != STAT_DONE), rsp_payload_ff.request_end_offset == '0, "request end shown without line done")

endmodule
